// ----- rtl/psrf_pkg.sv -----
`default_nettype none

package psrf_pkg;

  // Per-CPU state store.
  localparam int NUM_CPUS   = 64;
  localparam int CPU_ADDR_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Field widths.
  localparam int CPU_W    = 6;
  localparam int TIME_W   = 64;
  localparam int CNT_W    = 64;
  localparam int WCOUNT_W = 32;
  localparam int FREQ_W   = 20;
  localparam int PCT_W    = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FREQ_W;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FREQ       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT_THRESHOLD = 2'd1;

  // Required count: ceil(freq * pct / 100) = floor((freq * pct + 99) * R >> 32)
  // with R = ceil(2^32 / 100). The error term stays far below one step for
  // every product of the two register widths.
  localparam int PROD_W      = FREQ_W + PCT_W;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam int NEED_W      = PROD_W + RECIP_W - RECIP_SHIFT;
  localparam logic [PROD_W-1:0]  PCT_ROUND = PROD_W'(99);
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(42949673);

  localparam logic [TIME_W-1:0]   NS_PER_SECOND = TIME_W'(1000000000);
  localparam logic [WCOUNT_W-1:0] WCOUNT_MAX    = '1;

  // Result queue between the update stage and the output port.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CPU_W-1:0]  cpu_index;
    logic [TIME_W-1:0] time_ns;
    logic [CNT_W-1:0]  sample_counter;
  } sample_t;

  typedef struct packed {
    logic             report;
    logic [CNT_W-1:0] cycle_delta;
    logic [CPU_W-1:0] cpu_echo;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]    last_count;
    logic [TIME_W-1:0]   window_start;
    logic [WCOUNT_W-1:0] window_count;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  // State lookup issued when a sample is accepted.
  typedef struct packed {
    logic                  valid;
    logic [CPU_ADDR_W-1:0] addr;
  } lookup_t;

  // Classified sample held in the front stage.
  typedef struct packed {
    logic    valid;
    logic    in_range;
    logic    thr_on;
    sample_t smp;
  } req_t;

  // State write from the update stage.
  typedef struct packed {
    logic                  en;
    logic [CPU_ADDR_W-1:0] addr;
    state_t                data;
  } wr_t;

endpackage

`default_nettype wire

// ----- rtl/psrf_ram.sv -----
`default_nettype none

module psrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psrf_front.sv -----
`default_nettype none

module psrf_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire psrf_pkg::sample_t                   sample,
  input  wire logic [psrf_pkg::PCT_W-1:0]          percent_threshold,
  input  wire logic                                hold,
  input  wire logic [psrf_pkg::QCNT_W-1:0]         q_count,
  output psrf_pkg::lookup_t                        lookup,
  output psrf_pkg::req_t                           req
);

  import psrf_pkg::*;

  logic [QCNT_W:0] committed;
  logic            accept;

  // Every sample in the front stage is sure to find a queue slot on the next edge.
  assign committed    = {1'b0, q_count} + (QCNT_W + 1)'(req.valid);
  assign sample_stall = hold || (committed >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept       = sample_valid && !sample_stall;

  assign lookup.valid = accept;
  assign lookup.addr  = sample.cpu_index[CPU_ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= accept;
    end
    if (accept) begin
      req.in_range <= 32'(sample.cpu_index) < NUM_CPUS;
      req.thr_on   <= percent_threshold != '0;
      req.smp      <= sample;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psrf_update.sv -----
`default_nettype none

module psrf_update (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire psrf_pkg::lookup_t                 lookup,
  input  wire psrf_pkg::req_t                    req,
  input  wire psrf_pkg::state_t                  rd_state,
  input  wire logic [psrf_pkg::NEED_W-1:0]       need,
  output psrf_pkg::wr_t                          wr,
  output logic                                   push,
  output psrf_pkg::result_t                      push_data
);

  import psrf_pkg::*;

  logic [NUM_CPUS-1:0] ent_valid;
  logic                rd_valid;
  logic                fwd;
  state_t              fwd_state;
  state_t              cur;
  state_t              upd;
  logic [CNT_W:0]      cnt_diff;
  logic                rise;
  logic [TIME_W-1:0]   elapsed;
  logic                expired;
  logic [WCOUNT_W-1:0] n_inc;
  logic                report;

  // The store read for a sample overlaps the write of the sample just ahead
  // of it; when both hit the same CPU the written state is forwarded.
  always_ff @(posedge clk) begin
    if (lookup.valid) begin
      rd_valid  <= ent_valid[lookup.addr];
      fwd       <= wr.en && (wr.addr == lookup.addr);
      fwd_state <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr.en) begin
      ent_valid[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    if (fwd) begin
      cur = fwd_state;
    end else if (rd_valid) begin
      cur = rd_state;
    end else begin
      cur = '0;
    end
  end

  assign cnt_diff = {1'b0, req.smp.sample_counter} - {1'b0, cur.last_count};
  assign rise     = !cnt_diff[CNT_W] && (cnt_diff[CNT_W-1:0] != '0);
  assign elapsed  = req.smp.time_ns - cur.window_start;
  assign expired  = elapsed >= NS_PER_SECOND;
  assign n_inc    = (cur.window_count == WCOUNT_MAX) ? cur.window_count
                                                     : cur.window_count + 1'b1;

  always_comb begin
    upd.last_count   = rise ? req.smp.sample_counter : cur.last_count;
    upd.window_start = cur.window_start;
    upd.window_count = cur.window_count;
    report           = 1'b1;
    if (req.thr_on) begin
      if (expired) begin
        upd.window_start = req.smp.time_ns;
        upd.window_count = WCOUNT_W'(1);
        report           = 1'b0;
      end else begin
        upd.window_count = n_inc;
        report           = n_inc >= WCOUNT_W'(need);
      end
    end
  end

  assign wr.en   = req.valid && req.in_range;
  assign wr.addr = req.smp.cpu_index[CPU_ADDR_W-1:0];
  assign wr.data = upd;

  assign push                  = req.valid;
  assign push_data.report      = req.in_range && report;
  assign push_data.cycle_delta = (req.in_range && rise) ? cnt_diff[CNT_W-1:0] : '0;
  assign push_data.cpu_echo    = req.smp.cpu_index;

endmodule

`default_nettype wire

// ----- rtl/psrf_queue.sv -----
`default_nettype none

module psrf_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire psrf_pkg::result_t            push_data,
  output logic [psrf_pkg::QCNT_W-1:0]       count,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output psrf_pkg::result_t                 result
);

  import psrf_pkg::*;

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign result_valid = count != '0;
  assign result       = entries[rd_ptr];
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/per_cpu_sample_rate_filter.sv -----
// An accepted sample is registered in the front stage, then its result word is written
// into the result queue, whose head drives the result port. Throughput: one sample per
// cycle unless a register write or a full result queue stalls the input, set by the
// per-CPU state read-modify-write with forwarding; a four-word queue absorbs output stalls.
// Reset (synchronous, active high) clears both registers and all per-CPU state at once
// through per-entry valid bits; no clearing pass is run.
`default_nettype none

module per_cpu_sample_rate_filter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output logic                                    sample_stall,
  input  wire psrf_pkg::sample_t                  sample,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output psrf_pkg::result_t                       result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [psrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import psrf_pkg::*;

  logic [FREQ_W-1:0]          sample_freq;
  logic [PCT_W-1:0]           percent_threshold;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          prod_next;
  logic [NEED_W-1:0]          need;
  logic [PROD_W+RECIP_W-1:0]  scaled;
  logic [FREQ_W-1:0]          mul_freq;
  logic [PCT_W-1:0]           mul_pct;
  logic                       cfg_fire;
  logic                       cfg_pending;
  logic                       hold;
  logic [QCNT_W-1:0]          q_count;
  lookup_t                    lookup;
  req_t                       req;
  state_t                     rd_state;
  wr_t                        wr;
  logic                       push;
  result_t                    push_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // The rounded product is formed from the value being written and the other register.
  always_comb begin
    mul_freq = sample_freq;
    mul_pct  = percent_threshold;
    case (cfg_index)
      REG_SAMPLE_FREQ:       mul_freq = cfg_data[FREQ_W-1:0];
      REG_PERCENT_THRESHOLD: mul_pct  = cfg_data[PCT_W-1:0];
      default: begin
      end
    endcase
  end

  assign prod_next = PROD_W'(mul_freq) * PROD_W'(mul_pct) + PCT_ROUND;
  assign scaled    = {{RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_freq       <= '0;
      percent_threshold <= '0;
      prod              <= PCT_ROUND;
      need              <= '0;
      cfg_pending       <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_SAMPLE_FREQ:       sample_freq       <= cfg_data[FREQ_W-1:0];
          REG_PERCENT_THRESHOLD: percent_threshold <= cfg_data[PCT_W-1:0];
          default: begin
          end
        endcase
        prod <= prod_next;
      end
      need        <= scaled[RECIP_SHIFT +: NEED_W];
      cfg_pending <= cfg_fire;
    end
  end

  // Samples wait while the required count settles after a register write.
  assign hold = cfg_valid || cfg_pending;

  psrf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .sample            (sample),
    .percent_threshold (percent_threshold),
    .hold              (hold),
    .q_count           (q_count),
    .lookup            (lookup),
    .req               (req)
  );

  psrf_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_CPUS),
    .ADDR_W(CPU_ADDR_W)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (lookup.valid),
    .raddr (lookup.addr),
    .rdata (rd_state)
  );

  psrf_update u_update (
    .clk       (clk),
    .rst       (rst),
    .lookup    (lookup),
    .req       (req),
    .rd_state  (rd_state),
    .need      (need),
    .wr        (wr),
    .push      (push),
    .push_data (push_data)
  );

  psrf_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .count        (q_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue holds more words than its depth");

  a_accept_to_front: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> req.valid)
    else $error("accepted sample did not reach the front stage");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> req.valid && req.in_range)
    else $error("state write without an in-range sample");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push && (q_count == QCNT_W'(QUEUE_DEPTH)) |-> result_valid && !result_stall)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire
